// ----- hw/rtl/pav_pkg.sv -----
// ----------------------------------------------------------------------------
// pav_pkg: shared types and constants of the positional volume and pan core
// Item and result layouts, register indexes, fixed-point constants and the
// arctangent table of the sine/cosine rotator.
// ----------------------------------------------------------------------------
package pav_pkg;

   localparam int COORD_FRAC_BITS = 16;
   // distances at or below this (1e-4 in coordinate units) pan to centre
   localparam int NEAR_LIMIT      = (1 << COORD_FRAC_BITS) / 10000;
   localparam int QUIET_LIMIT     = 32;
   localparam int ONE_Q15         = 32768;
   localparam int HALF_Q15        = 16384;
   localparam int CORDIC_STEPS    = 14;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam int FIFO_DEPTH      = 2;

   localparam logic [1:0] CSR_LISTENER_X   = 2'd0;
   localparam logic [1:0] CSR_LISTENER_Y   = 2'd1;
   localparam logic [1:0] CSR_LISTENER_Z   = 2'd2;
   localparam logic [1:0] CSR_LISTENER_YAW = 2'd3;

   localparam logic ACT_PLAY   = 1'b0;
   localparam logic ACT_UPDATE = 1'b1;

   typedef struct packed {
      logic               action;
      logic [7:0]         tag;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
      logic [15:0]        base;
      logic [31:0]        maxd;
      logic [15:0]        yaw;
   } item_type;

   typedef struct packed {
      logic [7:0]  result_tag;
      logic [15:0] volume;
      logic [15:0] pan;
      logic        apply_levels;
      logic        start_voice;
   } result_type;

   // arctangent of 2^-i in binary angle units
   function automatic logic signed [16:0] atan_turn(input int idx);
      logic signed [16:0] val;
      begin
         case (idx)
            0:       val = 17'sd8192;
            1:       val = 17'sd4836;
            2:       val = 17'sd2555;
            3:       val = 17'sd1297;
            4:       val = 17'sd651;
            5:       val = 17'sd326;
            6:       val = 17'sd163;
            7:       val = 17'sd81;
            8:       val = 17'sd41;
            9:       val = 17'sd20;
            10:      val = 17'sd10;
            11:      val = 17'sd5;
            12:      val = 17'sd3;
            13:      val = 17'sd1;
            default: val = 17'sd0;
         endcase
         return val;
      end
   endfunction

endpackage

// ----- hw/rtl/positional_audio_volume_pan_core.sv -----
// ----------------------------------------------------------------------------
// positional_audio_volume_pan_core: distance attenuation and stereo pan
// Per-voice volume and pan from source position against a listener.
//
// Use: write listener x, y, z (Q16.16) and yaw (binary angle) on the csr
// port while the core is idle. Push items on req_ (accepted when req_push is
// high and req_full low); take results from rsp_ (the oldest result is shown
// while rsp_empty is low and is transferred when rsp_pop is high).
// Every item yields exactly one result, in order.
// Throughput: one item per cycle while the result queue has room. An item
// passes the work queue, the 32-stage square root, the 17-stage pan divider
// and the result queue on its way to the rsp_ ports.
// Reset clears the listener registers to zero and empties both queues.
// When the receiver stalls, the result queue fills, then the whole pipeline
// holds, then the work queue fills and req_full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module positional_audio_volume_pan_core import pav_pkg::*; #(
   parameter int QUEUE_DEPTH = FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [7:0]         req_voice_tag,
   input  logic signed [31:0] req_source_x,
   input  logic signed [31:0] req_source_y,
   input  logic signed [31:0] req_source_z,
   input  logic [15:0]        req_base_volume,
   input  logic [31:0]        req_max_distance,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [7:0]         rsp_result_tag,
   output logic [15:0]        rsp_volume,
   output logic [15:0]        rsp_pan,
   output logic               rsp_apply_levels,
   output logic               rsp_start_voice,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int ITEM_W = $bits(item_type);
   localparam int RES_W  = $bits(result_type);

   item_type          fr_item, mid_item;
   logic              fr_push, mid_full, mid_empty, mid_pop;
   logic [ITEM_W-1:0] mid_bits;
   result_type        bk_res, rsp_res;
   logic              bk_push, out_full;
   logic [RES_W-1:0]  out_bits;

   pav_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_action       (req_action),
      .req_voice_tag    (req_voice_tag),
      .req_source_x     (req_source_x),
      .req_source_y     (req_source_y),
      .req_source_z     (req_source_z),
      .req_base_volume  (req_base_volume),
      .req_max_distance (req_max_distance),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .item             (fr_item),
      .item_push        (fr_push),
      .queue_full       (mid_full)
   );

   pav_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_work_q (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_push),
      .push_data (fr_item),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_bits),
      .empty     (mid_empty)
   );

   assign mid_item = item_type'(mid_bits);

   pav_back u_back (
      .clock       (clock),
      .reset       (reset),
      .item        (mid_item),
      .item_valid  (!mid_empty),
      .item_take   (mid_pop),
      .result      (bk_res),
      .result_push (bk_push),
      .result_full (out_full)
   );

   pav_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (bk_push),
      .push_data (bk_res),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_bits),
      .empty     (rsp_empty)
   );

   assign rsp_res          = result_type'(out_bits);
   assign rsp_result_tag   = rsp_res.result_tag;
   assign rsp_volume       = rsp_res.volume;
   assign rsp_pan          = rsp_res.pan;
   assign rsp_apply_levels = rsp_res.apply_levels;
   assign rsp_start_voice  = rsp_res.start_voice;

endmodule

// ----- hw/rtl/pav_fifo.sv -----
// ----------------------------------------------------------------------------
// pav_fifo: small register queue
// Queue of DEPTH entries (power of two) with first-word fall-through output.
// ----------------------------------------------------------------------------
module pav_fifo import pav_pkg::*; #(
   parameter int WIDTH = 8,
   parameter int DEPTH = FIFO_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- hw/rtl/pav_front.sv -----
// ----------------------------------------------------------------------------
// pav_front: listener registers and item intake
// Holds the listener position and heading, takes request items and forms
// the source-minus-listener differences for the work queue.
// ----------------------------------------------------------------------------
module pav_front import pav_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_action,
   input  logic [7:0]         req_voice_tag,
   input  logic signed [31:0] req_source_x,
   input  logic signed [31:0] req_source_y,
   input  logic signed [31:0] req_source_z,
   input  logic [15:0]        req_base_volume,
   input  logic [31:0]        req_max_distance,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output item_type           item,
   output logic               item_push,
   input  logic               queue_full
);

   logic signed [31:0] lx_ff, ly_ff, lz_ff;
   logic [15:0]        yaw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lx_ff  <= '0;
         ly_ff  <= '0;
         lz_ff  <= '0;
         yaw_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LISTENER_X:   lx_ff  <= csr_wdata;
            CSR_LISTENER_Y:   ly_ff  <= csr_wdata;
            CSR_LISTENER_Z:   lz_ff  <= csr_wdata;
            CSR_LISTENER_YAW: yaw_ff <= csr_wdata[15:0];
            default:          ;
         endcase
      end
   end

   assign req_full  = queue_full;
   assign item_push = req_push && !queue_full;

   always_comb begin
      item.action = req_action;
      item.tag    = req_voice_tag;
      item.dx     = 33'(req_source_x) - 33'(lx_ff);
      item.dy     = 33'(req_source_y) - 33'(ly_ff);
      item.dz     = 33'(req_source_z) - 33'(lz_ff);
      // saturate base volume to unity
      item.base   = (req_base_volume > 16'(ONE_Q15)) ? 16'(ONE_Q15) : req_base_volume;
      item.maxd   = req_max_distance;
      item.yaw    = yaw_ff;
   end

endmodule

// ----- hw/rtl/pav_back.sv -----
// ----------------------------------------------------------------------------
// pav_back: distance, attenuation and pan pipeline
// Squares, square root, sine/cosine rotator and two restoring dividers, one
// stage per step, all advancing together under a single stall.
// ----------------------------------------------------------------------------
module pav_back import pav_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       item_valid,
   output logic       item_take,
   output result_type result,
   output logic       result_push,
   input  logic       result_full
);

   localparam int RT_STEPS = 32;
   localparam int AD_STEPS = 16;
   localparam int PD_STEPS = 17;
   localparam int S_RT0    = 3;
   localparam int S_CS     = CORDIC_STEPS + 1;
   localparam int S_AD0    = S_RT0 + RT_STEPS;
   localparam int S_MAG    = S_AD0 + 2;
   localparam int S_PD0    = S_AD0 + 3;
   localparam int S_ATT    = S_AD0 + AD_STEPS + 1;
   localparam int S_VOL    = S_ATT + 1;
   localparam int S_LAST   = S_PD0 + PD_STEPS + 1;

   typedef struct packed {
      logic               action;
      logic [7:0]         tag;
      logic [15:0]        base;
      logic [31:0]        maxd;
      logic signed [32:0] dx;
      logic signed [32:0] dz;
      logic signed [16:0] cs;
      logic signed [16:0] sn;
      logic [31:0]        distance;
      logic [15:0]        vol;
      logic               zero;
      logic               far;
      logic               near;
      logic               neg;
      logic               ovf;
   } side_type;

   function automatic logic [31:0] mag32(input logic signed [32:0] d);
      logic signed [32:0] n;
      begin
         n = -d;
         return d[32] ? n[31:0] : d[31:0];
      end
   endfunction

   logic              en;
   logic [S_LAST:0]   vld_ff;
   item_type          in_ff;
   side_type          side_ff [1:S_LAST-1];
   side_type          side_first;

   assign en          = !vld_ff[S_LAST] || !result_full;
   assign item_take   = en && item_valid;
   assign result_push = vld_ff[S_LAST] && !result_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[S_LAST-1:0], item_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) in_ff <= item;
   end

   // squares and saturating sum
   logic [63:0] sq_ff [3];
   logic [63:0] sum_ff;
   logic [65:0] sum_w;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff[0] <= mag32(in_ff.dx) * mag32(in_ff.dx);
         sq_ff[1] <= mag32(in_ff.dy) * mag32(in_ff.dy);
         sq_ff[2] <= mag32(in_ff.dz) * mag32(in_ff.dz);
      end
   end

   assign sum_w = 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);

   always_ff @(posedge clock) begin
      if (en) sum_ff <= (|sum_w[65:64]) ? '1 : sum_w[63:0];
   end

   // square root, one result bit per stage
   logic [63:0] rt_r_ff [RT_STEPS];
   logic [63:0] rt_v_ff [RT_STEPS-1];

   for (genvar j = 0; j < RT_STEPS; j++) begin : g_rt
      localparam logic [63:0] BITV = 64'd1 << (62 - 2 * j);
      logic [63:0] v_prev, r_prev, r_in;
      logic [64:0] trial;
      logic        ge;
      if (j == 0) begin : g_first
         assign v_prev = sum_ff;
         assign r_prev = '0;
      end else begin : g_rest
         assign v_prev = rt_v_ff[j-1];
         assign r_prev = rt_r_ff[j-1];
      end
      assign trial = {1'b0, r_prev} + {1'b0, BITV};
      assign ge    = ({1'b0, v_prev} >= trial);
      assign r_in  = ge ? ((r_prev >> 1) + BITV) : (r_prev >> 1);
      always_ff @(posedge clock) begin
         if (en) rt_r_ff[j] <= r_in;
      end
      if (j < RT_STEPS - 1) begin : g_v
         logic [63:0] v_in;
         assign v_in = ge ? (v_prev - trial[63:0]) : v_prev;
         always_ff @(posedge clock) begin
            if (en) rt_v_ff[j] <= v_in;
         end
      end
   end

   // sine and cosine of the heading
   logic signed [16:0] a0;
   logic               neg0;
   logic signed [33:0] cx_ff [CORDIC_STEPS];
   logic signed [33:0] cy_ff [CORDIC_STEPS];
   logic signed [16:0] ca_ff [CORDIC_STEPS-1];
   logic               cneg_ff [CORDIC_STEPS];

   always_comb begin
      a0   = {in_ff.yaw[15], in_ff.yaw};
      neg0 = 1'b0;
      // fold into the right half-plane
      if (a0 > 17'sd16384) begin
         a0   = a0 - 17'sd32768;
         neg0 = 1'b1;
      end else if (a0 < -17'sd16384) begin
         a0   = a0 + 17'sd32768;
         neg0 = 1'b1;
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      logic signed [33:0] x_prev, y_prev, x_in, y_in;
      logic signed [16:0] a_prev;
      logic               n_prev;
      if (i == 0) begin : g_first
         assign x_prev = CORDIC_GAIN;
         assign y_prev = '0;
         assign a_prev = a0;
         assign n_prev = neg0;
      end else begin : g_rest
         assign x_prev = cx_ff[i-1];
         assign y_prev = cy_ff[i-1];
         assign a_prev = ca_ff[i-1];
         assign n_prev = cneg_ff[i-1];
      end
      assign x_in = (a_prev >= 0) ? (x_prev - (y_prev >>> i)) : (x_prev + (y_prev >>> i));
      assign y_in = (a_prev >= 0) ? (y_prev + (x_prev >>> i)) : (y_prev - (x_prev >>> i));
      always_ff @(posedge clock) begin
         if (en) begin
            cx_ff[i]   <= x_in;
            cy_ff[i]   <= y_in;
            cneg_ff[i] <= n_prev;
         end
      end
      if (i < CORDIC_STEPS - 1) begin : g_a
         logic signed [16:0] a_in;
         assign a_in = (a_prev >= 0) ? (a_prev - atan_turn(i)) : (a_prev + atan_turn(i));
         always_ff @(posedge clock) begin
            if (en) ca_ff[i] <= a_in;
         end
      end
   end

   logic signed [33:0] cx_fin, cy_fin, cx_rnd, cy_rnd;
   assign cx_fin = cneg_ff[CORDIC_STEPS-1] ? -cx_ff[CORDIC_STEPS-1] : cx_ff[CORDIC_STEPS-1];
   assign cy_fin = cneg_ff[CORDIC_STEPS-1] ? -cy_ff[CORDIC_STEPS-1] : cy_ff[CORDIC_STEPS-1];
   assign cx_rnd = cx_fin + 34'sd16384;
   assign cy_rnd = cy_fin + 34'sd16384;

   // attenuation divider: (max - d) * 2^15 / max
   logic [31:0] dist_w, diff_w;
   logic [32:0] ad_rem_ff [AD_STEPS];
   logic [15:0] ad_q_ff   [1:AD_STEPS];
   logic        ad_lsb_ff;

   assign dist_w = rt_r_ff[RT_STEPS-1][31:0];
   assign diff_w = side_ff[S_AD0-1].maxd - dist_w;

   always_ff @(posedge clock) begin
      if (en) begin
         ad_rem_ff[0] <= {2'b00, diff_w[31:1]};
         ad_lsb_ff    <= diff_w[0];
      end
   end

   for (genvar t = 1; t <= AD_STEPS; t++) begin : g_ad
      logic [33:0] rem2;
      logic [31:0] dvs;
      logic [15:0] q_prev;
      logic        ge;
      assign dvs = side_ff[S_AD0+t-1].maxd;
      if (t == 1) begin : g_first
         assign rem2   = {ad_rem_ff[0], ad_lsb_ff};
         assign q_prev = '0;
      end else begin : g_rest
         assign rem2   = {ad_rem_ff[t-1], 1'b0};
         assign q_prev = ad_q_ff[t-1];
      end
      assign ge = (rem2 >= {2'b00, dvs});
      always_ff @(posedge clock) begin
         if (en) ad_q_ff[t] <= {q_prev[14:0], ge};
      end
      if (t < AD_STEPS) begin : g_rem
         logic [33:0] rem_in;
         assign rem_in = ge ? (rem2 - {2'b00, dvs}) : rem2;
         always_ff @(posedge clock) begin
            if (en) ad_rem_ff[t] <= rem_in[32:0];
         end
      end
   end

   logic [31:0] rr_w, vv_w;
   logic [15:0] att_ff;

   assign rr_w = (32'(ad_q_ff[AD_STEPS]) * 32'(ad_q_ff[AD_STEPS])) + 32'd16384;

   always_ff @(posedge clock) begin
      if (en) begin
         if (side_ff[S_ATT-1].zero)     att_ff <= 16'(ONE_Q15);
         else if (side_ff[S_ATT-1].far) att_ff <= '0;
         else                           att_ff <= rr_w[30:15];
      end
   end

   assign vv_w = (32'(side_ff[S_VOL-1].base) * 32'(att_ff)) + 32'd16384;

   // pan numerator and divider: (dz*cos - dx*sin) / (2d)
   logic signed [49:0] pm_z_ff, pm_x_ff;
   logic signed [50:0] num_ff, num_neg;
   logic [50:0]        pmag_ff;
   logic [32:0]        pdiv0;

   always_ff @(posedge clock) begin
      if (en) begin
         pm_z_ff <= side_ff[S_AD0-1].dz * side_ff[S_AD0-1].cs;
         pm_x_ff <= side_ff[S_AD0-1].dx * side_ff[S_AD0-1].sn;
         num_ff  <= 51'(pm_z_ff) - 51'(pm_x_ff);
         pmag_ff <= num_ff[50] ? num_neg : num_ff;
      end
   end

   assign num_neg = -num_ff;
   assign pdiv0   = {side_ff[S_PD0-1].distance, 1'b0};

   logic [33:0] pd_rem_ff [PD_STEPS];
   logic [16:0] pd_low_ff [PD_STEPS];
   logic [16:0] pd_q_ff   [1:PD_STEPS];

   always_ff @(posedge clock) begin
      if (en) begin
         pd_rem_ff[0] <= pmag_ff[50:17];
         pd_low_ff[0] <= pmag_ff[16:0];
      end
   end

   for (genvar t = 1; t <= PD_STEPS; t++) begin : g_pd
      logic [34:0] rem2, dvs;
      logic [16:0] q_prev;
      logic        ge;
      assign dvs  = {1'b0, side_ff[S_PD0+t-1].distance, 1'b0};
      assign rem2 = {pd_rem_ff[t-1], pd_low_ff[t-1][16]};
      if (t == 1) begin : g_first
         assign q_prev = '0;
      end else begin : g_rest
         assign q_prev = pd_q_ff[t-1];
      end
      assign ge = (rem2 >= dvs);
      always_ff @(posedge clock) begin
         if (en) pd_q_ff[t] <= {q_prev[15:0], ge};
      end
      if (t < PD_STEPS) begin : g_rem
         logic [34:0] rem_in;
         assign rem_in = ge ? (rem2 - dvs) : rem2;
         always_ff @(posedge clock) begin
            if (en) begin
               pd_rem_ff[t] <= rem_in[33:0];
               pd_low_ff[t] <= {pd_low_ff[t-1][15:0], 1'b0};
            end
         end
      end
   end

   // side band travelling with each item
   always_comb begin
      side_first        = '0;
      side_first.action = in_ff.action;
      side_first.tag    = in_ff.tag;
      side_first.base   = in_ff.base;
      side_first.maxd   = in_ff.maxd;
      side_first.dx     = in_ff.dx;
      side_first.dz     = in_ff.dz;
   end

   for (genvar k = 1; k < S_LAST; k++) begin : g_side
      side_type side_prev, side_in;
      if (k == 1) begin : g_first
         assign side_prev = side_first;
      end else begin : g_rest
         assign side_prev = side_ff[k-1];
      end
      always_comb begin
         side_in = side_prev;
         if (k == S_CS) begin
            side_in.cs = cx_rnd[31:15];
            side_in.sn = cy_rnd[31:15];
         end
         if (k == S_AD0) begin
            side_in.distance = dist_w;
            side_in.zero     = (side_prev.maxd == '0);
            side_in.far      = (dist_w >= side_prev.maxd);
            side_in.near     = (dist_w <= 32'(NEAR_LIMIT));
         end
         if (k == S_MAG) side_in.neg = num_ff[50];
         if (k == S_PD0) side_in.ovf = ({1'b0, pmag_ff[50:17]} >= {1'b0, pdiv0});
         if (k == S_VOL) side_in.vol = vv_w[30:15];
      end
      always_ff @(posedge clock) begin
         if (en) side_ff[k] <= side_in;
      end
   end

   // final pan, clamp and flags
   side_type           fin;
   logic signed [18:0] qs, pv;
   logic [15:0]        pan_w;
   result_type         res_in, res_ff;

   assign fin = side_ff[S_LAST-1];
   assign qs  = fin.neg ? -19'(pd_q_ff[PD_STEPS]) : 19'(pd_q_ff[PD_STEPS]);
   assign pv  = 19'sd16384 - qs;

   always_comb begin
      if (fin.near)              pan_w = 16'(HALF_Q15);
      else if (fin.ovf)          pan_w = fin.neg ? 16'(ONE_Q15) : 16'd0;
      else if (pv < 0)           pan_w = 16'd0;
      else if (pv > 19'sd32768)  pan_w = 16'(ONE_Q15);
      else                       pan_w = pv[15:0];
      res_in.result_tag = fin.tag;
      res_in.volume     = fin.vol;
      res_in.pan        = pan_w;
      if (fin.action == ACT_UPDATE) begin
         res_in.apply_levels = 1'b1;
         res_in.start_voice  = 1'b0;
      end else if (fin.vol <= 16'(QUIET_LIMIT)) begin
         // drop inaudible start
         res_in.apply_levels = 1'b0;
         res_in.start_voice  = 1'b0;
      end else begin
         res_in.apply_levels = 1'b1;
         res_in.start_voice  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

// ----- dv/positional_audio_volume_pan_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_audio_volume_pan_core_test: self-checking bench of the pan core
// Drives directed and random voice items through the queue interface under
// several idling mixes, predicts volume and pan per item with a behavioural
// model of the distance, attenuation and sine/cosine arithmetic, and checks
// every transfer on the result side in order.
// ----------------------------------------------------------------------------
module positional_audio_volume_pan_core_test;
   import pav_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_push;
   logic               req_full;
   logic               req_action;
   logic [7:0]         req_voice_tag;
   logic signed [31:0] req_source_x;
   logic signed [31:0] req_source_y;
   logic signed [31:0] req_source_z;
   logic [15:0]        req_base_volume;
   logic [31:0]        req_max_distance;
   logic               rsp_empty;
   logic               rsp_pop;
   logic [7:0]         rsp_result_tag;
   logic [15:0]        rsp_volume;
   logic [15:0]        rsp_pan;
   logic               rsp_apply_levels;
   logic               rsp_start_voice;
   logic               csr_wr_en;
   logic [1:0]         csr_index;
   logic [31:0]        csr_wdata;

   positional_audio_volume_pan_core uut (.*);

   typedef struct {
      logic        action;
      logic [7:0]  tag;
      logic [31:0] sx, sy, sz;
      logic [15:0] base;
      logic [31:0] maxd;
   } voice_item;

   typedef struct {
      logic        known;
      result_type  res;
   } voice_row;

   // listener copy
   logic signed [63:0] lis_x, lis_y, lis_z;
   logic [15:0]        lis_yaw;

   result_type levels_due[$];
   int  errors;
   int  send_idle_pct, recv_stall_pct;
   int  recv_hold;
   int  rows_sent;

   // ---------------- predictor ----------------
   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void yaw_sincos(input logic [15:0] yaw,
                                      output longint sn, output longint cs);
      int     a;
      bit     flip;
      longint x, y, nx;
      int     tbl[14];
      tbl = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};
      a = int'(yaw);
      flip = 0;
      x = 652032874;
      y = 0;
      if (a >= 32768) a -= 65536;
      if (a > 16384) begin
         a -= 32768; flip = 1;
      end else if (a < -16384) begin
         a += 32768; flip = 1;
      end
      for (int i = 0; i < 14; i++) begin
         if (a >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            a -= tbl[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            a += tbl[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x; y = -y;
      end
      cs = (x + (1 << 14)) >>> 15;
      sn = (y + (1 << 14)) >>> 15;
   endfunction

   function automatic logic [63:0] add_square(input logic [63:0] acc,
                                              input longint d);
      logic [63:0] m, s;
      m = (d < 0) ? 64'(-d) : 64'(d);
      s = m * m;
      return (acc > 64'hFFFF_FFFF_FFFF_FFFF - s) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + s;
   endfunction

   function automatic result_type spatialise(input voice_item it);
      result_type  r;
      longint      dx, dy, dz, sn, cs, num, q, p;
      logic [63:0] sum, distance, att, vol, base, frac;
      dx = longint'($signed(it.sx)) - lis_x;
      dy = longint'($signed(it.sy)) - lis_y;
      dz = longint'($signed(it.sz)) - lis_z;
      base = (it.base > ONE_Q15) ? ONE_Q15 : it.base;
      sum = add_square(0, dx);
      sum = add_square(sum, dy);
      sum = add_square(sum, dz);
      distance = floor_sqrt(sum);
      if (it.maxd == 0) att = ONE_Q15;
      else if (distance >= it.maxd) att = 0;
      else begin
         frac = ((it.maxd - distance) << 15) / it.maxd;
         att = (frac * frac + 16384) >> 15;
      end
      vol = (base * att + 16384) >> 15;
      p = HALF_Q15;
      if (distance > NEAR_LIMIT) begin
         yaw_sincos(lis_yaw, sn, cs);
         num = dz * cs - dx * sn;
         q = num / longint'(2 * distance);
         p = HALF_Q15 - q;
         if (p < 0) p = 0;
         if (p > ONE_Q15) p = ONE_Q15;
      end
      r.result_tag = it.tag;
      r.volume = vol[15:0];
      r.pan = p[15:0];
      if (it.action == ACT_UPDATE) begin
         r.apply_levels = 1; r.start_voice = 0;
      end else if (vol <= QUIET_LIMIT) begin
         r.apply_levels = 0; r.start_voice = 0;
      end else begin
         r.apply_levels = 1; r.start_voice = 1;
      end
      return r;
   endfunction

   // ---------------- clock, limit ----------------
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------- receiver ----------------
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (levels_due.size() == 0) begin
            $display("%0t: unexpected result tag %0d", $time, rsp_result_tag);
            errors++;
         end else begin
            result_type e;
            e = levels_due.pop_front();
            if (e !== {rsp_result_tag, rsp_volume, rsp_pan,
                       rsp_apply_levels, rsp_start_voice}) begin
               $display("%0t: expected tag %0d vol %0d pan %0d apply %0d start %0d,",
                        $time, e.result_tag, e.volume, e.pan, e.apply_levels,
                        e.start_voice);
               $display("%0t:   actual tag %0d vol %0d pan %0d apply %0d start %0d",
                        $time, rsp_result_tag, rsp_volume, rsp_pan,
                        rsp_apply_levels, rsp_start_voice);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_pop <= 0;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------- sender ----------------
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 0;
      case (idx)
         CSR_LISTENER_X:   lis_x = longint'($signed(val));
         CSR_LISTENER_Y:   lis_y = longint'($signed(val));
         CSR_LISTENER_Z:   lis_z = longint'($signed(val));
         CSR_LISTENER_YAW: lis_yaw = val[15:0];
         default: ;
      endcase
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_push <= 0;
      while (levels_due.size() != 0 && guard < 200000) begin
         @(negedge clock);
         guard++;
      end
      repeat (80) @(negedge clock);
   endtask

   // present one item at the falling edge, hold until a transfer
   task automatic push_voice(input voice_item it, input voice_row row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 0;
         @(negedge clock);
      end
      req_push         <= 1;
      req_action       <= it.action;
      req_voice_tag    <= it.tag;
      req_source_x     <= it.sx;
      req_source_y     <= it.sy;
      req_source_z     <= it.sz;
      req_base_volume  <= it.base;
      req_max_distance <= it.maxd;
      @(posedge clock);
      while (req_full) @(posedge clock);
      levels_due.push_back(row.known ? row.res : spatialise(it));
      rows_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_coord;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(2000000)) - 1000000);
         default: return 32'($signed($urandom_range(60 << 16)) - (30 << 16));
      endcase
   endfunction

   function automatic voice_item rand_voice;
      voice_item it;
      it.action = $urandom_range(1);
      it.tag = $urandom;
      it.sx = lis_x[31:0] + rand_coord();
      it.sy = lis_y[31:0] + rand_coord();
      it.sz = lis_z[31:0] + rand_coord();
      if ($urandom_range(9) == 0) begin
         it.sx = $urandom; it.sy = $urandom; it.sz = $urandom;
      end
      case ($urandom_range(5))
         0: it.base = $urandom;
         1: it.base = $urandom_range(40);
         default: it.base = $urandom_range(ONE_Q15);
      endcase
      case ($urandom_range(4))
         0: it.maxd = 0;
         1: it.maxd = $urandom;
         default: it.maxd = $urandom_range(80 << 16);
      endcase
      return it;
   endfunction

   function automatic voice_row typed(input result_type r);
      voice_row v;
      v.known = 1; v.res = r;
      return v;
   endfunction

   voice_item stim_items[$];
   voice_row  stim_rows[$];

   task automatic add_row(input logic act, input logic [7:0] tag,
                          input logic [31:0] x, y, z, input logic [15:0] b,
                          input logic [31:0] m, input voice_row row);
      voice_item it;
      it.action = act; it.tag = tag; it.sx = x; it.sy = y; it.sz = z;
      it.base = b; it.maxd = m;
      stim_items.push_back(it);
      stim_rows.push_back(row);
   endtask

   initial begin
      voice_row chk;
      int phase;
      chk.known = 0;
      errors = 0;
      rows_sent = 0;
      recv_hold = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      lis_x = 0; lis_y = 0; lis_z = 0; lis_yaw = 0;
      reset = 1;
      req_push = 0; req_action = 0; req_voice_tag = 0;
      req_source_x = 0; req_source_y = 0; req_source_z = 0;
      req_base_volume = 0; req_max_distance = 0;
      rsp_pop = 0;
      csr_wr_en = 0; csr_index = CSR_LISTENER_X; csr_wdata = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed table; rows typed in where the outcome is plain
      add_row(ACT_PLAY, 8'h00, 0, 0, 0, 16'd32768, 0,
              typed('{8'h00, 16'd32768, 16'd16384, 1'b1, 1'b1}));
      add_row(ACT_PLAY, 8'hFF, 0, 0, 0, 16'hFFFF, 0,
              typed('{8'hFF, 16'd32768, 16'd16384, 1'b1, 1'b1}));
      add_row(ACT_PLAY, 8'h01, 0, 0, 0, 16'd32, 0,
              typed('{8'h01, 16'd32, 16'd16384, 1'b0, 1'b0}));
      add_row(ACT_UPDATE, 8'h02, 0, 0, 0, 16'd0, 0,
              typed('{8'h02, 16'd0, 16'd16384, 1'b1, 1'b0}));
      add_row(ACT_PLAY, 8'h03, 0, 0, 0, 16'd33, 0,
              typed('{8'h03, 16'd33, 16'd16384, 1'b1, 1'b1}));
      add_row(ACT_PLAY, 8'h04, 32'd6, 0, 0, 16'd32768, 0,
              typed('{8'h04, 16'd32768, 16'd16384, 1'b1, 1'b1}));
      add_row(ACT_PLAY, 8'h05, 32'd7, 0, 0, 16'd32768, 0, chk);
      add_row(ACT_PLAY, 8'h06, 32'(10 << 16), 0, 0, 16'd32768, 32'(10 << 16), chk);
      add_row(ACT_UPDATE, 8'h07, 0, 0, 32'(5 << 16), 16'd32768, 32'(10 << 16), chk);
      add_row(ACT_PLAY, 8'h08, 0, 0, 32'(-(5 << 16)), 16'd20000, 32'(10 << 16), chk);
      add_row(ACT_PLAY, 8'h09, 32'(3 << 16), 0, 0, 16'd32768, 32'hFFFF_FFFF, chk);
      add_row(ACT_PLAY, 8'h0A, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              16'd32768, 0, chk);
      add_row(ACT_UPDATE, 8'h0B, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              16'hFFFF, 32'hFFFF_FFFF, chk);
      add_row(ACT_PLAY, 8'h0C, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 16'd1, 32'd1,
              typed('{8'h0C, 16'd0, 16'd16384, 1'b0, 1'b0}));
      add_row(ACT_UPDATE, 8'hA5, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0,
              16'h5555, 32'hAAAA_5555, chk);
      for (int i = 0; i < stim_items.size(); i++) push_voice(stim_items[i], stim_rows[i]);
      drain();

      // listener settings and idling mixes, extremes first
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_LISTENER_X, 32'h8000_0000);
               write_reg(CSR_LISTENER_Y, 32'h7FFF_FFFF);
               write_reg(CSR_LISTENER_Z, 32'h8000_0000);
               write_reg(CSR_LISTENER_YAW, 32'h0000_FFFF);
            end
            1: begin
               write_reg(CSR_LISTENER_X, 32'h7FFF_FFFF);
               write_reg(CSR_LISTENER_Y, 32'h8000_0000);
               write_reg(CSR_LISTENER_Z, 32'h7FFF_FFFF);
               write_reg(CSR_LISTENER_YAW, 32'hFFFF_0000);
            end
            2: write_reg(CSR_LISTENER_YAW, 32'd16384);
            3: write_reg(CSR_LISTENER_YAW, 32'd32768);
            4: write_reg(CSR_LISTENER_YAW, 32'd49152);
            default: begin
               write_reg(CSR_LISTENER_X, $urandom);
               write_reg(CSR_LISTENER_Y, $urandom);
               write_reg(CSR_LISTENER_Z, $urandom);
               write_reg(CSR_LISTENER_YAW, $urandom);
            end
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 20; recv_stall_pct = 20; end
         endcase
         if (phase == 2) recv_hold = 300;  // fill the core and stall input
         for (int n = 0; n < 142; n++) begin
            push_voice(rand_voice(), chk);
            if (phase == 5 && n == 70) drain();
         end
         drain();
      end

      drain();
      if (errors == 0 && levels_due.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/pav_pkg.sv
hw/rtl/pav_fifo.sv
hw/rtl/pav_front.sv
hw/rtl/pav_back.sv
hw/rtl/positional_audio_volume_pan_core.sv
dv/positional_audio_volume_pan_core_test.sv
